// ===== rtl/lss_pkg.sv =====
// Shared types and constants for the LIFO stack with search.
// Holds the operation codes and the command and status bundles between
// the controller and the datapath. No dependencies.
package lss_pkg;

	// Fixed widths of the word fields.
	localparam int unsigned WORD_W = 32;
	localparam int unsigned POS_W  = 4;
	localparam int unsigned OCC_W  = 5;

	// Operation codes carried by the func field.
	typedef enum logic [1:0] {
		FUNC_PUSH   = 2'd0,
		FUNC_POP    = 2'd1,
		FUNC_PEEK   = 2'd2,
		FUNC_SEARCH = 2'd3
	} func_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;     // input word taken this cycle
		logic top_load;   // load the top register from the RAM read data
		logic srch_next;  // no match yet: read the next entry down
		logic srch_done;  // search ends this cycle, record the match flag
		logic load_out;   // capture the result into the output register
	} lss_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;      // no entries held
		logic single;     // exactly one entry held
		logic match;      // RAM read data equals the search word
		logic last;       // the entry being compared is the bottom one
		logic out_busy;   // output register holds a word not yet taken
	} lss_stat_t;

endpackage

// ===== rtl/lss_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Stands alone; used by the stack datapath for entry storage.
module lss_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds when no read is issued.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/lss_ctrl.sv =====
// Controller state machine of the LIFO stack with search.
// Depends on lss_pkg for the command and status bundles and the op codes.
module lss_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        func,
	input  lss_pkg::lss_stat_t stat,
	output lss_pkg::lss_cmd_t  cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_POP  = 4'b0010,
		S_SRCH = 4'b0100,
		S_RES  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	lss_pkg::func_t op;

	assign op       = lss_pkg::func_t'(func);
	assign in_ready = (state_q == S_IDLE);

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					unique case (op)
						lss_pkg::FUNC_POP: begin
							// A new top must come from the RAM unless the stack empties.
							if (stat.empty || stat.single) begin
								state_d = S_RES;
							end else begin
								state_d = S_POP;
							end
						end
						lss_pkg::FUNC_SEARCH: begin
							state_d = stat.empty ? S_RES : S_SRCH;
						end
						default: begin
							state_d = S_RES;
						end
					endcase
				end
			end
			S_POP: begin
				cmd.top_load = 1'b1;
				state_d      = S_RES;
			end
			S_SRCH: begin
				if (stat.match || stat.last) begin
					cmd.srch_done = 1'b1;
					state_d       = S_RES;
				end else begin
					cmd.srch_next = 1'b1;
				end
			end
			S_RES: begin
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef ASSERT_OFF
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state is not one-hot");

	a_load_only_in_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (state_q == S_IDLE))
		else $error("result loaded without returning to idle");

	a_search_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SRCH) && stat.last |=> (state_q != S_SRCH))
		else $error("search ran past the bottom entry");
`endif

endmodule

// ===== rtl/lss_dp.sv =====
// Datapath of the LIFO stack with search: fill count, cached top word,
// search cursor, entry RAM and the output register.
// Depends on lss_pkg and lss_ram.
module lss_dp #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [1:0]                         func,
	input  logic signed [lss_pkg::WORD_W-1:0]  value,
	input  lss_pkg::lss_cmd_t                  cmd,
	output lss_pkg::lss_stat_t                 stat,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [lss_pkg::WORD_W-1:0]  top_value,
	output logic                               found,
	output logic [lss_pkg::POS_W-1:0]          position,
	output logic [lss_pkg::OCC_W-1:0]          occupancy,
	output logic                               is_empty,
	output logic                               overflow
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (AW > lss_pkg::POS_W) ? AW : lss_pkg::POS_W;
	localparam int unsigned OW = (CW > lss_pkg::OCC_W) ? CW : lss_pkg::OCC_W;

	lss_pkg::func_t op;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] dist_q;
	logic [lss_pkg::WORD_W-1:0] top_q;
	logic [lss_pkg::WORD_W-1:0] key_q;
	logic found_q;
	logic ovf_q;
	logic full;
	logic do_push;
	logic do_pop;
	logic wr_en;
	logic rd_en;
	logic [CW-1:0] rd_off;
	logic [CW-1:0] rd_ptr;
	logic [lss_pkg::WORD_W-1:0] rd_data;
	logic [PW-1:0] dist_ext;
	logic [OW-1:0] fill_ext;

	assign op      = lss_pkg::func_t'(func);
	assign full    = (fill_q == CW'(DEPTH));
	assign do_push = cmd.accept && (op == lss_pkg::FUNC_PUSH) && !full;
	assign do_pop  = cmd.accept && (op == lss_pkg::FUNC_POP) && !stat.empty;

	// Status toward the controller.
	assign stat.empty    = (fill_q == '0);
	assign stat.single   = (fill_q == CW'(1));
	assign stat.match    = (rd_data == key_q);
	assign stat.last     = ((CW'(dist_q) + CW'(1)) == fill_q);
	assign stat.out_busy = out_valid && !out_ready;

	// RAM read pointer: entry fill-1-off, counted down from the top.
	always_comb begin
		rd_en  = 1'b0;
		rd_off = '0;
		if (cmd.accept && (op == lss_pkg::FUNC_POP) && !stat.empty && !stat.single) begin
			rd_en  = 1'b1;
			rd_off = CW'(1);
		end else if (cmd.accept && (op == lss_pkg::FUNC_SEARCH) && !stat.empty) begin
			rd_en  = 1'b1;
			rd_off = '0;
		end else if (cmd.srch_next) begin
			rd_en  = 1'b1;
			rd_off = CW'(dist_q) + CW'(1);
		end
	end

	assign rd_ptr = fill_q - CW'(1) - rd_off;
	assign wr_en  = do_push;

	lss_ram #(
		.WIDTH (lss_pkg::WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (fill_q[AW-1:0]),
		.wr_data (value),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr[AW-1:0]),
		.rd_data (rd_data)
	);

	// Fill count and per-word flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			found_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			if (do_push) begin
				fill_q <= fill_q + CW'(1);
			end else if (do_pop) begin
				fill_q <= fill_q - CW'(1);
			end
			if (cmd.accept) begin
				found_q <= 1'b0;
				ovf_q   <= (op == lss_pkg::FUNC_PUSH) && full;
			end else if (cmd.srch_done) begin
				found_q <= stat.match;
			end
		end
	end

	// Cached top word, search key and search cursor.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q  <= value;
			dist_q <= '0;
		end else if (cmd.srch_next) begin
			dist_q <= dist_q + AW'(1);
		end
		if (do_push) begin
			top_q <= value;
		end else if (cmd.top_load) begin
			top_q <= rd_data;
		end
	end

	assign dist_ext = PW'(dist_q);
	assign fill_ext = OW'(fill_q);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			top_value <= stat.empty ? '0 : top_q;
			found     <= found_q;
			position  <= found_q ? dist_ext[lss_pkg::POS_W-1:0] : '0;
			occupancy <= fill_ext[lss_pkg::OCC_W-1:0];
			is_empty  <= stat.empty;
			overflow  <= ovf_q;
		end
	end

`ifndef ASSERT_OFF
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count exceeds depth");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> (fill_q == $past(fill_q) + CW'(1)))
		else $error("push did not advance the fill count");

	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (CW'(dist_q) < fill_q))
		else $error("match distance lies beyond the held entries");

	a_ram_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("RAM written and read in the same cycle");
`endif

endmodule

// ===== rtl/lifo_stack_with_search.sv =====
// LIFO stack of DEPTH signed 32-bit words with push, pop, peek and search.
// An item is taken only when the controller is idle. Push, peek, a pop that
// leaves the stack empty or finds it empty, and a search of an empty stack go
// from acceptance straight to the result state; a pop that leaves entries
// behind passes first through a pop state, because the new top is read back
// from the entry RAM through its registered read port. A search compares one
// entry per cycle, walking down from the top through that same read port,
// until it finds a match or reaches the bottom entry. The next item can be
// accepted back in idle, once its predecessor's result word is loaded into
// the output register, even if that word has not yet been taken.
module lifo_stack_with_search #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [1:0]                         func,
	input  logic signed [lss_pkg::WORD_W-1:0]  value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [lss_pkg::WORD_W-1:0]  top_value,
	output logic                               found,
	output logic [lss_pkg::POS_W-1:0]          position,
	output logic [lss_pkg::OCC_W-1:0]          occupancy,
	output logic                               is_empty,
	output logic                               overflow
);

	lss_pkg::lss_cmd_t  cmd;
	lss_pkg::lss_stat_t stat;

	// Sequencer for the operations.
	lss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.func     (func),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Storage, search and result register.
	lss_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.func      (func),
		.value     (value),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.top_value (top_value),
		.found     (found),
		.position  (position),
		.occupancy (occupancy),
		.is_empty  (is_empty),
		.overflow  (overflow)
	);

endmodule

// ===== verif/tb_lifo_stack_with_search.sv =====
// Self-checking testbench for lifo_stack_with_search: a directed opening and
// a long random run of push, pop, peek and search words, checked against an
// internal stack predictor. Depends on lss_pkg and the stack RTL.
module tb_lifo_stack_with_search;
	import lss_pkg::*;

	localparam int unsigned STACK_DEPTH = 16;
	localparam int unsigned RANDOM_OPS = 1850;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned LONG_HOLD = 80;
	localparam int unsigned DRAIN_CYCLES = STACK_DEPTH + 8;
	localparam int unsigned MAX_REPORTS = 10;
	localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [WORD_W-1:0] WORD_ALL_ONES = -32'sd1;

	// One operation word to send, with the idle gap that follows it.
	typedef struct {
		func_t                    op;
		logic signed [WORD_W-1:0] word;
		int unsigned              gap;
	} stack_op_t;

	// One predicted status word.
	typedef struct {
		logic signed [WORD_W-1:0] top_value;
		logic                     found;
		logic [POS_W-1:0]         position;
		logic [OCC_W-1:0]         occupancy;
		logic                     is_empty;
		logic                     overflow;
	} stack_status_t;

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [1:0]               func;
	logic signed [WORD_W-1:0] value;
	logic                     out_valid;
	logic                     out_ready;
	logic signed [WORD_W-1:0] top_value;
	logic                     found;
	logic [POS_W-1:0]         position;
	logic [OCC_W-1:0]         occupancy;
	logic                     is_empty;
	logic                     overflow;

	stack_op_t     op_queue[$];
	stack_status_t status_queue[$];

	// Predictor state: held words, bottom at index 0.
	logic signed [WORD_W-1:0] held_words[STACK_DEPTH];
	int unsigned              held_count;

	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned hold_left;
	int unsigned taken_count;
	int unsigned mismatch_count;
	int unsigned cycle_count;

	lifo_stack_with_search #(
		.DEPTH(STACK_DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.top_value (top_value),
		.found     (found),
		.position  (position),
		.occupancy (occupancy),
		.is_empty  (is_empty),
		.overflow  (overflow)
	);

	// Clock with an 8 unit period.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Applies one accepted operation to the predictor and queues its status word.
	function automatic void apply_stack_op(func_t op, logic signed [WORD_W-1:0] word);
		stack_status_t st;
		st = '{default: '0};
		case (op)
			FUNC_PUSH: begin
				if (held_count < STACK_DEPTH) begin
					held_words[held_count] = word;
					held_count++;
				end else begin
					st.overflow = 1'b1;
				end
			end
			FUNC_POP: begin
				if (held_count > 0)
					held_count--;
			end
			FUNC_SEARCH: begin
				for (int d = 0; d < held_count; d++) begin
					if (held_words[held_count - 1 - d] == word) begin
						st.found = 1'b1;
						st.position = POS_W'(d);
						break;
					end
				end
			end
			default: ;
		endcase
		st.top_value = (held_count > 0) ? held_words[held_count - 1] : '0;
		st.occupancy = OCC_W'(held_count);
		st.is_empty = (held_count == 0);
		status_queue.push_back(st);
	endfunction

	function automatic void add_op(func_t op, logic signed [WORD_W-1:0] word,
			int unsigned gap);
		stack_op_t item;
		item.op = op;
		item.word = word;
		item.gap = gap;
		op_queue.push_back(item);
	endfunction

	// Sender: presents queued words, holds them until taken, then idles per word.
	always @(posedge clk or negedge arst_n) begin : sender
		stack_op_t item;
		logic      valid_next;
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= FUNC_PEEK;
			value <= '0;
			gap_left <= 0;
		end else begin
			valid_next = in_valid;
			if (in_valid && in_ready) begin
				apply_stack_op(func_t'(func), value);
				valid_next = 1'b0;
			end
			if (!valid_next) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (op_queue.size() > 0) begin
					item = op_queue.pop_front();
					func <= item.op;
					value <= item.word;
					gap_left <= item.gap;
					valid_next = 1'b1;
				end
			end
			in_valid <= valid_next;
		end
	end

	// Receiver: random short stalls, quiet stretches, and two long hold-offs
	// that let the block back up and stall its input.
	always @(posedge clk or negedge arst_n) begin : receiver
		logic        taken;
		int unsigned draw;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			hold_left <= 0;
			taken_count <= 0;
		end else begin
			taken = out_valid && out_ready;
			if (taken)
				taken_count <= taken_count + 1;
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (taken && (taken_count == 300 || taken_count == 1200)) begin
				hold_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else if (taken) begin
				draw = ((taken_count / 250) % 4 == 1) ? 0 : $urandom_range(0, 3);
				if (draw == 0) begin
					out_ready <= 1'b1;
				end else begin
					stall_left <= draw - 1;
					out_ready <= 1'b0;
				end
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Checker: every taken status word against the oldest prediction.
	always @(posedge clk) begin : result_monitor
		stack_status_t want;
		if (arst_n && out_valid && out_ready) begin
			if (status_queue.size() == 0) begin
				if (mismatch_count < MAX_REPORTS)
					$display("Unexpected status word: top=%0d occ=%0d", top_value, occupancy);
				mismatch_count <= mismatch_count + 1;
			end else begin
				want = status_queue.pop_front();
				if (top_value !== want.top_value || found !== want.found ||
						position !== want.position || occupancy !== want.occupancy ||
						is_empty !== want.is_empty || overflow !== want.overflow) begin
					if (mismatch_count < MAX_REPORTS) begin
						$display("Mismatch: expected top=%0d found=%0b pos=%0d occ=%0d empty=%0b ovf=%0b",
							want.top_value, want.found, want.position, want.occupancy,
							want.is_empty, want.overflow);
						$display("          actual   top=%0d found=%0b pos=%0d occ=%0d empty=%0b ovf=%0b",
							top_value, found, position, occupancy, is_empty, overflow);
					end
					mismatch_count <= mismatch_count + 1;
				end
			end
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		logic signed [WORD_W-1:0] pool[8];
		logic signed [WORD_W-1:0] word;
		func_t                    op;
		int unsigned              pick;
		int unsigned              phase;
		int unsigned              gap;

		arst_n = 1'b0;
		cycle_count = 0;
		mismatch_count = 0;
		held_count = 0;

		// Empty stack: peek gives zero, pop does nothing, search misses.
		add_op(FUNC_PEEK, 32'sd77, 0);
		add_op(FUNC_POP, WORD_ALL_ONES, 1);
		add_op(FUNC_SEARCH, 32'sd0, 0);
		// Extreme words, then searches that hit at depth and miss.
		add_op(FUNC_PUSH, WORD_MAX, 0);
		add_op(FUNC_PUSH, WORD_MIN, 2);
		add_op(FUNC_PUSH, WORD_ALL_ONES, 0);
		add_op(FUNC_PUSH, 32'sd0, 3);
		add_op(FUNC_SEARCH, WORD_MIN, 0);
		add_op(FUNC_SEARCH, 32'sd0, 0);
		add_op(FUNC_SEARCH, 32'sd5, 1);
		add_op(FUNC_PEEK, WORD_MAX, 0);
		// Duplicate word: the copy nearest the top wins.
		add_op(FUNC_PUSH, WORD_MIN, 0);
		add_op(FUNC_SEARCH, WORD_MIN, 0);
		// Fill to capacity, then a dropped push and a search reaching the bottom.
		for (int i = 0; i < STACK_DEPTH - 5; i++)
			add_op(FUNC_PUSH, WORD_W'(32'sh1111_1111 * (i + 1)), 0);
		add_op(FUNC_PUSH, 32'sd42, 0);
		add_op(FUNC_SEARCH, WORD_MAX, 0);
		add_op(FUNC_POP, 32'sd0, 0);

		// Random part: push-heavy, pop-heavy and balanced phases so the stack
		// sweeps between empty and full; a small pool makes searches hit.
		pool = '{WORD_MIN, WORD_MAX, WORD_ALL_ONES, 32'sd0, 32'sd1, 32'sd2,
			32'sh5A5A_A5A5, -32'sd1000};
		for (int k = 0; k < RANDOM_OPS; k++) begin
			phase = (k / 64) % 3;
			pick = $urandom_range(0, 99);
			if (phase == 0)
				op = (pick < 60) ? FUNC_PUSH : (pick < 75) ? FUNC_POP :
					(pick < 85) ? FUNC_PEEK : FUNC_SEARCH;
			else if (phase == 1)
				op = (pick < 15) ? FUNC_PUSH : (pick < 65) ? FUNC_POP :
					(pick < 75) ? FUNC_PEEK : FUNC_SEARCH;
			else
				op = (pick < 35) ? FUNC_PUSH : (pick < 60) ? FUNC_POP :
					(pick < 70) ? FUNC_PEEK : FUNC_SEARCH;
			pick = $urandom_range(0, 9);
			if (pick < 5)
				word = pool[$urandom_range(0, 7)];
			else
				word = $urandom;
			gap = ((k / 150) % 5 == 2) ? 0 : $urandom_range(0, 3);
			add_op(op, word, gap);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (op_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (status_queue.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && status_queue.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
